// ===== hdl/assert_macros.svh =====
// Assertion helpers; build with NO_ASSERTIONS defined to strip them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PPS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler check failed");
`define PPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler sequencing check failed");
`else
`define PPS_ASSERT_IMPL(label, ante, cons)
`define PPS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/pps_pkg.sv =====
package pps_pkg;

   localparam int DEFAULT_MAX_PROCESSES = 16;
   localparam logic [15:0] TICK_MAX = 16'hFFFF;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [7:0]  proc_id;
      logic [15:0] arrival_tick;
      logic [7:0]  burst_len;
      logic [7:0]  prio_level;
   } req_type;

   typedef struct packed {
      logic        load_rejected;
      logic        running_valid;
      logic [7:0]  running_id;
      logic [7:0]  remaining_before;
      logic        finished;
      logic [15:0] finish_tick;
      logic [15:0] turnaround;
      logic [15:0] waiting_cycles;
      logic [15:0] tick_now;
      logic        all_done;
   } rsp_type;

   // one process table slot
   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] arrival;
      logic [7:0]  burst;
      logic [7:0]  rem;
      logic [7:0]  prio;
   } entry_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic        load;
      logic        mark;
      logic        update;
      logic        take;
      logic        run_flag;
      logic        finish;
      logic [15:0] tick;
      entry_type   entry;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   // decision stage, waiting for the waiting-time subtract
   typedef struct packed {
      logic        running_valid;
      logic [7:0]  id;
      logic [7:0]  rem;
      logic        finished;
      logic [15:0] fin;
      logic [15:0] tat;
      logic [7:0]  burst;
      logic [15:0] tick_now;
      logic        all_done;
   } stage_type;

endpackage

// ===== hdl/pps_chan_if.sv =====
interface pps_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/pps_cell.sv =====
module pps_cell import pps_pkg::*; #(
   parameter int SLOT_W = 4,
   parameter int CNT_W  = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] slot_idx,
   input  cell_cmd_type      cmd,
   input  logic [CNT_W-1:0]  load_count,
   input  logic [SLOT_W-1:0] run_slot,
   input  logic [SLOT_W-1:0] best_slot,
   input  logic              in_have,
   input  logic [SLOT_W-1:0] in_slot,
   input  entry_type         in_best,
   input  logic              in_run_have,
   input  entry_type         in_run,
   output logic              out_have,
   output logic [SLOT_W-1:0] out_slot,
   output entry_type         out_best,
   output logic              out_run_have,
   output entry_type         out_run
);

   entry_type         entry_ff, entry_in;
   logic              ready_ff, ready_in;
   logic              done_ff, done_in;
   logic              have_ff, have_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   entry_type         best_ff, best_in;
   logic              run_have_ff, run_have_in;
   entry_type         run_ff, run_in;

   logic loaded;
   logic is_run;
   logic mine;
   logic served;

   assign loaded = (CNT_W'(slot_idx) < load_count);
   assign is_run = cmd.run_flag && (slot_idx == run_slot);
   assign mine   = loaded && ready_ff && (!in_have || (entry_ff.prio < in_best.prio));
   assign served = cmd.take ? (slot_idx == best_slot) : is_run;

   always_comb begin
      entry_in = entry_ff;
      ready_in = ready_ff;
      done_in  = done_ff;
      if (cmd.load && (slot_idx == load_count[SLOT_W-1:0])) begin
         entry_in = cmd.entry;
         ready_in = 1'b0;
         done_in  = 1'b0;
      end
      if (cmd.mark && loaded && (entry_ff.arrival == cmd.tick) &&
          !ready_ff && !done_ff && !is_run) begin
         ready_in = 1'b1;
      end
      if (cmd.update) begin
         if (cmd.take && (slot_idx == best_slot)) begin
            ready_in = 1'b0;
         end
         if (cmd.take && is_run) begin
            ready_in = 1'b1;   // preempted, back in the queue
         end
         if (served) begin
            entry_in.rem = entry_ff.rem - 8'd1;
            if (cmd.finish) begin
               done_in = 1'b1;
            end
         end
      end
   end

   // token walk: best ready entry so far, and the running entry's data
   always_comb begin
      have_in     = in_have;
      slot_in     = in_slot;
      best_in     = in_best;
      run_have_in = in_run_have;
      run_in      = in_run;
      if (mine) begin
         have_in = 1'b1;
         slot_in = slot_idx;
         best_in = entry_ff;
      end
      if (is_run) begin
         run_have_in = 1'b1;
         run_in      = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff    <= 1'b0;
         done_ff     <= 1'b0;
         have_ff     <= 1'b0;
         run_have_ff <= 1'b0;
      end else begin
         ready_ff    <= ready_in;
         done_ff     <= done_in;
         have_ff     <= have_in;
         run_have_ff <= run_have_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      slot_ff  <= slot_in;
      best_ff  <= best_in;
      run_ff   <= run_in;
   end

   assign out_have     = have_ff;
   assign out_slot     = slot_ff;
   assign out_best     = best_ff;
   assign out_run_have = run_have_ff;
   assign out_run      = run_ff;

endmodule

// ===== hdl/preemptive_priority_scheduler_core.sv =====
// Load transaction: result registered at acceptance, one per cycle unless stalled.
// Tick transaction: the priority token walks the cell chain in ST_SCAN, then
//   ST_DECIDE and ST_FINISH register the result; no request is taken meanwhile.
// Reset (synchronous, active high) clears the ready/done bits, counters, running
//   state and sequencer; table contents are undefined until loaded.
`include "assert_macros.svh"
module preemptive_priority_scheduler_core import pps_pkg::*; #(
   parameter int MAX_PROCESSES = DEFAULT_MAX_PROCESSES
) (
   input logic       clock,
   input logic       reset,
   pps_chan_if.sink   req_ch,
   pps_chan_if.source rsp_ch
);

   localparam int SLOT_W = $clog2(MAX_PROCESSES);
   localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);

   // ------------------------------------------------------------------
   // Sequencer and global state
   // ------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0]  loaded_count_ff, loaded_count_in;
   logic [CNT_W-1:0]  completed_count_ff, completed_count_in;
   logic [15:0]       tick_counter_ff, tick_counter_in;
   logic [SLOT_W-1:0] running_slot_ff, running_slot_in;
   logic              running_flag_ff, running_flag_in;
   stage_type         stage_ff, stage_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   cell_cmd_type      cmd;

   // token chain between cells; index 0 is the empty seed
   logic              have_w     [0:MAX_PROCESSES];
   logic [SLOT_W-1:0] slot_w     [0:MAX_PROCESSES];
   entry_type         best_w     [0:MAX_PROCESSES];
   logic              run_have_w [0:MAX_PROCESSES];
   entry_type         run_w      [0:MAX_PROCESSES];

   req_type           req;
   logic              req_fire;
   logic              load_reject;
   logic [CNT_W-1:0]  loaded_next;

   // decision terms, valid in ST_DECIDE
   entry_type         tok_best;
   entry_type         tok_run;
   logic              take;
   logic              serve_valid;
   entry_type         served;
   logic              finish;
   logic [15:0]       fin;
   logic [15:0]       tat;
   logic [CNT_W-1:0]  completed_next;
   logic [15:0]       wait_cycles;

   assign req            = req_ch.payload;
   assign req_ch.ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

   // Table full or zero burst refuses the load and leaves state alone.
   assign load_reject = (loaded_count_ff >= CNT_W'(MAX_PROCESSES)) || (req.burst_len == 8'd0);
   assign loaded_next = loaded_count_ff + CNT_W'(!load_reject);

   // Preempt only on a strictly smaller priority number; ties keep the
   // running process. Lowest slot wins among equal ready entries (cell rule).
   assign tok_best    = best_w[MAX_PROCESSES];
   assign tok_run     = run_w[MAX_PROCESSES];
   assign take        = have_w[MAX_PROCESSES] &&
                        (!running_flag_ff || (tok_best.prio < tok_run.prio));
   assign serve_valid = take || running_flag_ff;
   assign served      = take ? tok_best : tok_run;
   assign finish      = serve_valid && (served.rem == 8'd1);

   // finish tick saturates, turnaround and waiting time floor at zero
   assign fin = (tick_counter_ff != TICK_MAX) ? (tick_counter_ff + 16'd1) : TICK_MAX;
   assign tat = (fin >= served.arrival) ? (fin - served.arrival) : 16'd0;
   assign completed_next = completed_count_ff + CNT_W'(finish);

   assign wait_cycles = (stage_ff.finished && (stage_ff.tat >= {8'd0, stage_ff.burst})) ?
                        (stage_ff.tat - {8'd0, stage_ff.burst}) : 16'd0;

   always_comb begin
      state_in           = state_ff;
      scan_cnt_in        = scan_cnt_ff;
      loaded_count_in    = loaded_count_ff;
      completed_count_in = completed_count_ff;
      tick_counter_in    = tick_counter_ff;
      running_slot_in    = running_slot_ff;
      running_flag_in    = running_flag_ff;
      stage_in           = stage_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ch.ready;
      rsp_payload_in     = rsp_payload_ff;

      cmd             = '0;
      cmd.run_flag    = running_flag_ff;
      cmd.tick        = tick_counter_ff;
      cmd.entry.id      = req.proc_id;
      cmd.entry.arrival = req.arrival_tick;
      cmd.entry.burst   = req.burst_len;
      cmd.entry.rem     = req.burst_len;
      cmd.entry.prio    = req.prio_level;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.mode == MODE_LOAD) begin
                  // load completes at acceptance
                  cmd.load                = !load_reject;
                  loaded_count_in         = loaded_next;
                  rsp_payload_in          = '0;
                  rsp_payload_in.load_rejected = load_reject;
                  rsp_payload_in.tick_now = tick_counter_ff;
                  rsp_payload_in.all_done = (completed_count_ff == loaded_next);
                  rsp_valid_in            = 1'b1;
               end else begin
                  // arrivals are marked on the acceptance edge
                  cmd.mark    = 1'b1;
                  scan_cnt_in = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // one cell per cycle until the token leaves the last cell
            if (scan_cnt_ff == SLOT_W'(MAX_PROCESSES - 1)) begin
               state_in = ST_DECIDE;
            end else begin
               scan_cnt_in = scan_cnt_ff + SLOT_W'(1);
            end
         end
         ST_DECIDE: begin
            cmd.update         = 1'b1;
            cmd.take           = take;
            cmd.finish         = finish;
            running_slot_in    = take ? slot_w[MAX_PROCESSES] : running_slot_ff;
            running_flag_in    = serve_valid && !finish;
            completed_count_in = completed_next;
            tick_counter_in    = fin;

            stage_in.running_valid = serve_valid;
            stage_in.id            = serve_valid ? served.id : 8'd0;
            stage_in.rem           = serve_valid ? served.rem : 8'd0;
            stage_in.finished      = finish;
            stage_in.fin           = finish ? fin : 16'd0;
            stage_in.tat           = finish ? tat : 16'd0;
            stage_in.burst         = served.burst;
            stage_in.tick_now      = tick_counter_ff;
            stage_in.all_done      = (completed_next == loaded_count_ff);
            state_in               = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_payload_in.load_rejected    = 1'b0;
               rsp_payload_in.running_valid    = stage_ff.running_valid;
               rsp_payload_in.running_id       = stage_ff.id;
               rsp_payload_in.remaining_before = stage_ff.rem;
               rsp_payload_in.finished         = stage_ff.finished;
               rsp_payload_in.finish_tick      = stage_ff.fin;
               rsp_payload_in.turnaround       = stage_ff.tat;
               rsp_payload_in.waiting_cycles   = wait_cycles;
               rsp_payload_in.tick_now         = stage_ff.tick_now;
               rsp_payload_in.all_done         = stage_ff.all_done;
               rsp_valid_in                    = 1'b1;
               state_in                        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         scan_cnt_ff        <= '0;
         loaded_count_ff    <= '0;
         completed_count_ff <= '0;
         tick_counter_ff    <= '0;
         running_slot_ff    <= '0;
         running_flag_ff    <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         scan_cnt_ff        <= scan_cnt_in;
         loaded_count_ff    <= loaded_count_in;
         completed_count_ff <= completed_count_in;
         tick_counter_ff    <= tick_counter_in;
         running_slot_ff    <= running_slot_in;
         running_flag_ff    <= running_flag_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff       <= stage_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // ------------------------------------------------------------------
   // Cell chain: each cell holds one table slot and forwards the best
   // ready candidate and the running entry's data to its neighbor.
   // ------------------------------------------------------------------
   assign have_w[0]     = 1'b0;
   assign slot_w[0]     = '0;
   assign best_w[0]     = '0;
   assign run_have_w[0] = 1'b0;
   assign run_w[0]      = '0;

   for (genvar k = 0; k < MAX_PROCESSES; k++) begin : g_cell
      pps_cell #(
         .SLOT_W (SLOT_W),
         .CNT_W  (CNT_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .slot_idx     (SLOT_W'(k)),
         .cmd          (cmd),
         .load_count   (loaded_count_ff),
         .run_slot     (running_slot_ff),
         .best_slot    (slot_w[MAX_PROCESSES]),
         .in_have      (have_w[k]),
         .in_slot      (slot_w[k]),
         .in_best      (best_w[k]),
         .in_run_have  (run_have_w[k]),
         .in_run       (run_w[k]),
         .out_have     (have_w[k+1]),
         .out_slot     (slot_w[k+1]),
         .out_best     (best_w[k+1]),
         .out_run_have (run_have_w[k+1]),
         .out_run      (run_w[k+1])
      );
   end

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `PPS_ASSERT_IMPL(a_run_slot_loaded, running_flag_ff, CNT_W'(running_slot_ff) < loaded_count_ff)
   `PPS_ASSERT_IMPL(a_completed_le_loaded, 1'b1, completed_count_ff <= loaded_count_ff)
   `PPS_ASSERT_IMPL(a_tick_held_in_scan, state_ff == ST_SCAN, $stable(tick_counter_ff))
   `PPS_ASSERT_IMPL(a_run_token_found, state_ff == ST_DECIDE && running_flag_ff, run_have_w[MAX_PROCESSES])
   `PPS_ASSERT_NEXT(a_decide_to_finish, state_ff == ST_DECIDE, state_ff == ST_FINISH)

endmodule

// ===== tb/preemptive_priority_scheduler_core_test.sv =====
`timescale 1ns / 1ps

// Testbench for the preemptive priority scheduler core.
// A scoreboard object carries its own copy of the process table and predicts
// one result per accepted transaction; the result monitor pops and compares
// field by field.
module preemptive_priority_scheduler_core_test import pps_pkg::*;;

   localparam int NPROC       = DEFAULT_MAX_PROCESSES;
   localparam int RANDOM_ITEMS = 1200;
   localparam int MAX_REPORTS = 40;
   localparam int REQ_W       = $bits(req_type);

   // ------------------------------------------------------------------
   // Scoreboard: process table model plus the queue of expected results
   // ------------------------------------------------------------------
   class sched_scoreboard;
      entry_type   proc_tbl[NPROC];
      bit          is_ready[NPROC];
      bit          is_done[NPROC];
      int unsigned loaded = 0;
      int unsigned completed = 0;
      logic [15:0] tick = '0;
      int unsigned run_slot = 0;
      bit          run_flag = 1'b0;

      rsp_type     pending[$];
      int unsigned errors = 0;

      // run statistics for the summary
      int unsigned n_loads = 0, n_rejected = 0, n_ticks = 0, n_idle = 0;
      int unsigned n_saturated = 0, n_finished = 0, n_preempt = 0;

      function rsp_type schedule_step(req_type r);
         rsp_type     o;
         int unsigned n;
         int unsigned best;
         bit          have_best;
         logic [15:0] fin, tat, wt;
         o = '0;
         o.tick_now = tick;
         if (r.mode == MODE_LOAD) begin
            n_loads++;
            if (loaded >= NPROC || r.burst_len == 8'd0) begin
               o.load_rejected = 1'b1;
               n_rejected++;
            end else begin
               proc_tbl[loaded].id      = r.proc_id;
               proc_tbl[loaded].arrival = r.arrival_tick;
               proc_tbl[loaded].burst   = r.burst_len;
               proc_tbl[loaded].rem     = r.burst_len;
               proc_tbl[loaded].prio    = r.prio_level;
               is_ready[loaded] = 1'b0;
               is_done[loaded]  = 1'b0;
               loaded++;
            end
         end else begin
            n_ticks++;
            if (tick == TICK_MAX) n_saturated++;
            n = (loaded < NPROC) ? loaded : NPROC;
            // arrivals: never queue an entry twice
            for (int i = 0; i < n; i++) begin
               if (proc_tbl[i].arrival == tick && !is_ready[i] && !is_done[i] &&
                   !(run_flag && run_slot == i))
                  is_ready[i] = 1'b1;
            end
            // best ready entry, lowest slot on ties
            have_best = 1'b0;
            best = 0;
            for (int i = 0; i < n; i++) begin
               if (is_ready[i] && (!have_best || proc_tbl[i].prio < proc_tbl[best].prio)) begin
                  best = i;
                  have_best = 1'b1;
               end
            end
            if (have_best && (!run_flag || proc_tbl[best].prio < proc_tbl[run_slot].prio)) begin
               if (run_flag) begin
                  is_ready[run_slot] = 1'b1;
                  n_preempt++;
               end
               is_ready[best] = 1'b0;
               run_slot = best;
               run_flag = 1'b1;
            end
            if (run_flag) begin
               o.running_valid    = 1'b1;
               o.running_id       = proc_tbl[run_slot].id;
               o.remaining_before = proc_tbl[run_slot].rem;
               proc_tbl[run_slot].rem = proc_tbl[run_slot].rem - 8'd1;
               if (proc_tbl[run_slot].rem == 8'd0) begin
                  fin = (tick < TICK_MAX) ? tick + 16'd1 : TICK_MAX;
                  tat = (fin >= proc_tbl[run_slot].arrival) ?
                        fin - proc_tbl[run_slot].arrival : 16'd0;
                  wt  = (tat >= {8'd0, proc_tbl[run_slot].burst}) ?
                        tat - {8'd0, proc_tbl[run_slot].burst} : 16'd0;
                  o.finished       = 1'b1;
                  o.finish_tick    = fin;
                  o.turnaround     = tat;
                  o.waiting_cycles = wt;
                  is_done[run_slot] = 1'b1;
                  completed++;
                  run_flag = 1'b0;
                  n_finished++;
               end
            end else begin
               n_idle++;
            end
            tick = (tick < TICK_MAX) ? tick + 16'd1 : TICK_MAX;
         end
         o.all_done = (completed == loaded);
         return o;
      endfunction

      function void note_request(req_type r);
         pending = {pending, schedule_step(r)};
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result with nothing expected, expected none, actual %p",
                        $time, got);
            return;
         end
         want = pending.pop_front();
         compare_field("load_rejected", want.load_rejected, got.load_rejected);
         compare_field("running_valid", want.running_valid, got.running_valid);
         compare_field("running_id", want.running_id, got.running_id);
         compare_field("remaining_before", want.remaining_before, got.remaining_before);
         compare_field("finished", want.finished, got.finished);
         compare_field("finish_tick", want.finish_tick, got.finish_tick);
         compare_field("turnaround", want.turnaround, got.turnaround);
         compare_field("waiting_cycles", want.waiting_cycles, got.waiting_cycles);
         compare_field("tick_now", want.tick_now, got.tick_now);
         compare_field("all_done", want.all_done, got.all_done);
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   pps_chan_if #(.payload_type(req_type)) req_if ();
   pps_chan_if #(.payload_type(rsp_type)) rsp_if ();

   preemptive_priority_scheduler_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   sched_scoreboard sb;

   // idle controls for the two sides; both go quiet for the last part
   bit send_idle_on  = 1'b0;
   bit stall_on      = 1'b0;
   int stall_left    = 0;

   // ------------------------------------------------------------------
   // Result side: check on every accepted transaction, then pick the
   // ready value for the next edge (one NBA per step).
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.payload);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side helpers
   // ------------------------------------------------------------------
   function automatic req_type load_item(logic [7:0] id, logic [15:0] arr,
                                         logic [7:0] burst, logic [7:0] prio);
      req_type r;
      r.mode         = MODE_LOAD;
      r.proc_id      = id;
      r.arrival_tick = arr;
      r.burst_len    = burst;
      r.prio_level   = prio;
      return r;
   endfunction

   // tick with junk in the unused fields, the block must ignore them
   function automatic req_type tick_item();
      req_type r;
      r = REQ_W'({$urandom, $urandom});
      r.mode = MODE_TICK;
      return r;
   endfunction

   // load arriving shortly after the current tick, so it actually runs
   function automatic req_type near_load_item();
      int unsigned arr;
      arr = sb.tick + $urandom_range(0, 30);
      if (arr > TICK_MAX) arr = 32'(TICK_MAX);
      return load_item(8'($urandom), arr[15:0], 8'($urandom_range(1, 12)), 8'($urandom));
   endfunction

   task automatic idle_sender(int cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // valid stays high across back-to-back transactions
   task automatic send_item(req_type item);
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(item);
      if (send_idle_on && $urandom_range(0, 4) == 0)
         idle_sender($urandom_range(1, 15));
   endtask

   // hold off until every outstanding result has come back
   task automatic drain_results();
      while (sb.pending.size() != 0) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      sb = new();
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      send_item(tick_item());                               // empty table, idle
      send_item(load_item(8'hFF, 16'hFFFF, 8'd0, 8'hFF));   // zero burst, rejected
      send_item(load_item(8'hA5, 16'd2, 8'd3, 8'd7));
      send_item(load_item(8'h5A, 16'd2, 8'd1, 8'd7));       // tie with slot 0
      send_item(load_item(8'h00, 16'd3, 8'd1, 8'd0));       // preempts slot 0
      send_item(load_item(8'h33, 16'd0, 8'd1, 8'd0));       // late, never ready
      send_item(load_item(8'hFE, 16'hFFFE, 8'd4, 8'd200));  // arrives near the top of range
      send_item(load_item(8'h01, 16'hFFFF, 8'd2, 8'd10));   // arrives at the top of range
      send_item(load_item(8'h80, 16'd6, 8'd255, 8'd255));   // longest burst, lowest prio
      repeat (7) send_item(tick_item());
      send_item(load_item(8'h55, 16'd8, 8'd1, 8'd255));     // equal prio, no preemption
      repeat (3) send_item(tick_item());
      drain_results();

      // --- random part: mostly ticks, loads mostly near the current tick ---
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 100 == 0) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            stall_on     = ($urandom_range(0, 3) != 0);
         end
         if (k == RANDOM_ITEMS / 2) drain_results();
         if ($urandom_range(0, 9) == 0) begin
            if (sb.loaded < NPROC && $urandom_range(0, 3) != 0) begin
               send_item(near_load_item());
            end else begin
               req_type noise;
               noise = REQ_W'({$urandom, $urandom});
               noise.mode = MODE_LOAD;
               send_item(noise);
            end
         end else begin
            send_item(tick_item());
         end
      end

      // --- last part, no idling on either side ---
      send_idle_on = 1'b0;
      stall_on     = 1'b0;
      drain_results();
      for (int k = 0; k < 300; k++) begin
         if ($urandom_range(0, 6) == 0) begin
            req_type noise;
            noise = REQ_W'({$urandom, $urandom});
            noise.mode = MODE_LOAD;
            send_item(noise);
         end else begin
            send_item(tick_item());
         end
      end

      // --- end of run ---
      drain_results();
      repeat (NPROC + 8) @(posedge clock);
      $display("Run covered %0d loads (%0d refused) and %0d ticks (%0d idle, %0d saturated).",
               sb.n_loads, sb.n_rejected, sb.n_ticks, sb.n_idle, sb.n_saturated);
      $display("Processes completed: %0d, preemptions: %0d, mismatches: %0d.",
               sb.n_finished, sb.n_preempt, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
